/* hw/rtl/u8v_pkg.sv */
// Shared types, constants and helpers for the UTF-8 stream validator.
`default_nettype none

package u8v_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 21;
   localparam int PEND_W  = 2;
   localparam int CLASS_W = 2;
   localparam int BITS_W  = 6;

   // Queue between the classifier and the sequence tracker
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Byte ranges and masks
   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hc0;
   localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hf4;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'h1f;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'h0f;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'h07;
   localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3f;

   // Code point limits
   localparam logic [CODE_W-1:0] MIN_CLASS2 = 21'h000080;
   localparam logic [CODE_W-1:0] MIN_CLASS3 = 21'h000800;
   localparam logic [CODE_W-1:0] MIN_CLASS4 = 21'h010000;
   localparam logic [CODE_W-1:0] MAX_CODE   = 21'h10ffff;
   localparam logic [CODE_W-1:0] SURR_LO    = 21'h00d800;
   localparam logic [CODE_W-1:0] SURR_HI    = 21'h00dfff;

   // Lead classes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_TWO  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_THREE = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_FOUR = 2'd3;

   // Byte kinds as decoded by the classifier
   typedef enum logic [2:0] {
      KIND_TERM,
      KIND_ASCII,
      KIND_CONT,
      KIND_LEAD2,
      KIND_LEAD3,
      KIND_LEAD4,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [BITS_W-1:0]   bits;
   } entry_type;

   // Smallest code point a sequence of the given class may encode
   function automatic logic [CODE_W-1:0] class_minimum(input logic [CLASS_W-1:0] cls);
      logic [CODE_W-1:0] result;
      case (cls)
         CLASS_TWO:   result = MIN_CLASS2;
         CLASS_THREE: result = MIN_CLASS3;
         default:     result = MIN_CLASS4;
      endcase
      return result;
   endfunction

   // Finished code point is in range for its class and not a surrogate
   function automatic logic code_ok(input logic [CODE_W-1:0] code,
                                    input logic [CLASS_W-1:0] cls);
      return (code >= class_minimum(cls)) && (code <= MAX_CODE) &&
             ((code < SURR_LO) || (code > SURR_HI));
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/u8v_req_if.sv */
// Request channel: one string byte per request.
`default_nettype none

interface u8v_req_if;
   logic                         valid;
   logic                         ready;
   logic [u8v_pkg::BYTE_W-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/u8v_rsp_if.sv */
// Response channel: one verdict per terminated string.
`default_nettype none

interface u8v_rsp_if;
   logic valid;
   logic ready;
   logic string_valid;

   modport source (output valid, output string_valid, input ready);
   modport sink   (input valid, input string_valid, output ready);
endinterface

`default_nettype wire

/* hw/rtl/u8v_front.sv */
// Front end: accepts request bytes and classifies them into queue entries.
`default_nettype none

module u8v_front (
   u8v_req_if.sink                  req_bus,
   output logic                     push_valid,
   output u8v_pkg::entry_type       push_entry,
   input  logic                     push_ready
);

   logic [u8v_pkg::BYTE_W-1:0] b;

   assign b = req_bus.in_byte;

   // Pass the handshake straight to the queue
   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;

   // Decode the byte kind and keep its payload bits
   always_comb begin
      push_entry.kind = u8v_pkg::KIND_BAD;
      push_entry.bits = '0;
      if (b == '0) begin
         push_entry.kind = u8v_pkg::KIND_TERM;
      end else if (b < u8v_pkg::ASCII_LIMIT) begin
         push_entry.kind = u8v_pkg::KIND_ASCII;
      end else if ((b & u8v_pkg::CONT_MASK) == u8v_pkg::CONT_TAG) begin
         push_entry.kind = u8v_pkg::KIND_CONT;
         push_entry.bits = u8v_pkg::BITS_W'(b & u8v_pkg::CONT_BITS);
      end else if (b >= u8v_pkg::LEAD2_LO && b <= u8v_pkg::LEAD2_HI) begin
         push_entry.kind = u8v_pkg::KIND_LEAD2;
         push_entry.bits = u8v_pkg::BITS_W'(b & u8v_pkg::LEAD2_MASK);
      end else if (b >= u8v_pkg::LEAD3_LO && b <= u8v_pkg::LEAD3_HI) begin
         push_entry.kind = u8v_pkg::KIND_LEAD3;
         push_entry.bits = u8v_pkg::BITS_W'(b & u8v_pkg::LEAD3_MASK);
      end else if (b >= u8v_pkg::LEAD4_LO && b <= u8v_pkg::LEAD4_HI) begin
         push_entry.kind = u8v_pkg::KIND_LEAD4;
         push_entry.bits = u8v_pkg::BITS_W'(b & u8v_pkg::LEAD4_MASK);
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/u8v_queue.sv */
// Short FIFO of classified bytes between the front end and the tracker.
`default_nettype none

module u8v_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  u8v_pkg::entry_type       push_entry,
   output logic                     push_ready,
   output logic                     head_valid,
   output u8v_pkg::entry_type       head_entry,
   input  logic                     pop
);

   localparam logic [u8v_pkg::COUNT_W-1:0] FULL = u8v_pkg::COUNT_W'(u8v_pkg::QUEUE_DEPTH);
   localparam logic [u8v_pkg::PTR_W-1:0]   LAST = u8v_pkg::PTR_W'(u8v_pkg::QUEUE_DEPTH - 1);

   u8v_pkg::entry_type               slot_ff [u8v_pkg::QUEUE_DEPTH];
   logic [u8v_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [u8v_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [u8v_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             push;

   assign push_ready = (count_ff != FULL);
   assign push       = push_valid && push_ready;
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("queue occupancy above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

endmodule

`default_nettype wire

/* hw/rtl/u8v_back.sv */
// Back end: tracks the UTF-8 sequence state and registers the verdict.
`default_nettype none

module u8v_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  u8v_pkg::entry_type       head_entry,
   output logic                     pop,
   u8v_rsp_if.source                rsp_bus
);

   logic [u8v_pkg::PEND_W-1:0]  pending_ff, pending_in;
   logic [u8v_pkg::CODE_W-1:0]  partial_ff, partial_in;
   logic [u8v_pkg::CLASS_W-1:0] lead_class_ff, lead_class_in;
   logic                        failed_ff, failed_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic                        out_free;
   logic                        is_term;
   logic [u8v_pkg::CODE_W-1:0]  code_next;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign is_term   = (head_entry.kind == u8v_pkg::KIND_TERM);
   // A terminator needs a free output slot; other bytes never stall
   assign pop       = head_valid && (!is_term || out_free);
   assign code_next = {partial_ff[u8v_pkg::CODE_W-u8v_pkg::BITS_W-1:0], head_entry.bits};

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.string_valid = rsp_ok_ff;

   // Sequence state update for the popped byte
   always_comb begin
      pending_in    = pending_ff;
      partial_in    = partial_ff;
      lead_class_in = lead_class_ff;
      failed_in     = failed_ff;
      rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      if (pop) begin
         if (is_term) begin
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = !failed_ff && (pending_ff == '0);
            pending_in    = '0;
            partial_in    = '0;
            lead_class_in = u8v_pkg::CLASS_NONE;
            failed_in     = 1'b0;
         end else if (failed_ff) begin
            // drop bytes until the terminator
         end else if (pending_ff != '0) begin
            if (head_entry.kind != u8v_pkg::KIND_CONT) begin
               failed_in  = 1'b1;
               pending_in = '0;
            end else begin
               partial_in = code_next;
               pending_in = pending_ff - 1'b1;
               if (pending_ff == 2'd1) begin
                  failed_in     = !u8v_pkg::code_ok(code_next, lead_class_ff);
                  partial_in    = '0;
                  lead_class_in = u8v_pkg::CLASS_NONE;
               end
            end
         end else begin
            unique case (head_entry.kind)
               u8v_pkg::KIND_ASCII: begin
               end
               u8v_pkg::KIND_LEAD2: begin
                  partial_in    = u8v_pkg::CODE_W'(head_entry.bits);
                  lead_class_in = u8v_pkg::CLASS_TWO;
                  pending_in    = 2'd1;
               end
               u8v_pkg::KIND_LEAD3: begin
                  partial_in    = u8v_pkg::CODE_W'(head_entry.bits);
                  lead_class_in = u8v_pkg::CLASS_THREE;
                  pending_in    = 2'd2;
               end
               u8v_pkg::KIND_LEAD4: begin
                  partial_in    = u8v_pkg::CODE_W'(head_entry.bits);
                  lead_class_in = u8v_pkg::CLASS_FOUR;
                  pending_in    = 2'd3;
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         partial_ff    <= '0;
         lead_class_ff <= u8v_pkg::CLASS_NONE;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         partial_ff    <= partial_in;
         lead_class_ff <= lead_class_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Verdict payload
   always_ff @(posedge clock) begin
      rsp_ok_ff <= rsp_ok_in;
   end

   a_failed_idle: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> pending_ff == '0)
      else $error("pending bytes while failed");

   a_pending_class: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != '0) |-> (lead_class_ff != u8v_pkg::CLASS_NONE &&
                              pending_ff <= lead_class_ff))
      else $error("pending count exceeds lead class");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && is_term) |=> (pending_ff == '0 && !failed_ff && rsp_valid_ff))
      else $error("terminator did not clear state and post verdict");

endmodule

`default_nettype wire

/* hw/rtl/utf8_stream_validator_unit.sv */
// Top level of the UTF-8 stream validator.
`default_nettype none

// Strict UTF-8 checker for zero-terminated strings, one byte per request.
// A zero byte ends the string and yields one response whose string_valid is
// 1 when every sequence was well formed (legal lead, 10xxxxxx continuations,
// not overlong, not a surrogate, not above 10FFFF) and no sequence was cut
// short; other bytes yield no response. The block takes one byte per clock
// while the queue has room: the classifier decodes each byte as it is
// accepted and writes it into a four-entry queue, and the sequence tracker
// retires one queue entry per clock. A verdict is registered after the
// tracker pops its terminator. Only a terminator waits on the response
// register, so a stalled response holds back the tracker solely when the
// next verdict is due, while the queue goes on taking bytes until it fills.
module utf8_stream_validator_unit (
   input  wire          clock,
   input  wire          reset,
   u8v_req_if.sink      req_bus,
   u8v_rsp_if.source    rsp_bus
);

   logic                  push_valid;
   logic                  push_ready;
   u8v_pkg::entry_type    push_entry;
   logic                  head_valid;
   u8v_pkg::entry_type    head_entry;
   logic                  pop;

   u8v_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   u8v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   u8v_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
